// ===== rtl/gyro_gesture_event_detector_assert.svh =====
// assertion macros for the gyro gesture event detector checker
// expects clk_i and rst_ni to be visible where the macros are used
`ifndef GYRO_GESTURE_EVENT_DETECTOR_ASSERT_SVH
`define GYRO_GESTURE_EVENT_DETECTOR_ASSERT_SVH

// general property, clocked on clk_i and disabled during reset
`define GGD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// payload holds while a transfer is stalled
`define GGD_ASSERT_HOLD(label, vld, rdy, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

// ===== rtl/ggd_pkg.sv =====
// shared types and constants for the gyro gesture event detector
// no dependencies
package ggd_pkg;

  // gesture codes as seen on the result channel
  typedef enum logic [2:0] {
    G_NONE        = 3'd0,
    G_ROTATE_CW   = 3'd1,
    G_ROTATE_CCW  = 3'd2,
    G_FLICK_UP    = 3'd3,
    G_FLICK_DOWN  = 3'd4,
    G_FLICK_LEFT  = 3'd5,
    G_FLICK_RIGHT = 3'd6
  } gesture_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_ROTATE   = 2'd1,
    CFG_FLICK    = 2'd2
  } cfg_idx_e;

  localparam int unsigned RateW   = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DebW    = 16;
  localparam int unsigned ThrW    = 15;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DebW-1:0] DebounceRst = 16'd300;
  localparam logic [ThrW-1:0] RotateRst   = 15'd1600;
  localparam logic [ThrW-1:0] FlickRst    = 15'd2400;

  // threshold crossings of one sample
  typedef struct packed {
    logic rot_pos;
    logic rot_neg;
    logic x_pos;
    logic x_neg;
    logic z_pos;
    logic z_neg;
  } ggd_flags_t;

endpackage

// ===== rtl/ggd_axis_cmp.sv =====
// threshold comparators for the three rate axes
// depends on ggd_pkg
module ggd_axis_cmp import ggd_pkg::*; (
  input  logic signed [RateW-1:0] rate_x_i,
  input  logic signed [RateW-1:0] rate_y_i,
  input  logic signed [RateW-1:0] rate_z_i,
  input  logic        [ThrW-1:0]  rotate_thr_i,
  input  logic        [ThrW-1:0]  flick_thr_i,
  output ggd_flags_t              flags_o
);

  logic signed [RateW:0] x_ext, y_ext, z_ext;
  logic signed [RateW:0] rot_pos_thr, rot_neg_thr, flk_pos_thr, flk_neg_thr;

  // sign-extend rates, thresholds get one extra bit for the negated form
  assign x_ext = {rate_x_i[RateW-1], rate_x_i};
  assign y_ext = {rate_y_i[RateW-1], rate_y_i};
  assign z_ext = {rate_z_i[RateW-1], rate_z_i};

  assign rot_pos_thr = $signed({2'b00, rotate_thr_i});
  assign flk_pos_thr = $signed({2'b00, flick_thr_i});
  assign rot_neg_thr = (RateW+1)'(0) - rot_pos_thr;
  assign flk_neg_thr = (RateW+1)'(0) - flk_pos_thr;

  // strict compares, a rate equal to a threshold is quiet
  always_comb begin
    flags_o.rot_pos = y_ext > rot_pos_thr;
    flags_o.rot_neg = y_ext < rot_neg_thr;
    flags_o.x_pos   = x_ext > flk_pos_thr;
    flags_o.x_neg   = x_ext < flk_neg_thr;
    flags_o.z_pos   = z_ext > flk_pos_thr;
    flags_o.z_neg   = z_ext < flk_neg_thr;
  end

endmodule

// ===== rtl/ggd_decide.sv =====
// gesture state, debounce window and decision priority
// depends on ggd_pkg
module ggd_decide import ggd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  ggd_flags_t       flags_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic [DebW-1:0]  debounce_i,
  output gesture_e         gesture_o
);

  gesture_e         cur_q, cur_d;
  logic [TimeW-1:0] last_q, last_d;
  logic [TimeW-1:0] elapsed;
  logic             open;
  logic             stamp;
  logic             is_rot;

  // wrapped time since the last stamped decision
  assign elapsed = now_ms_i - last_q;
  assign open    = elapsed >= {{(TimeW-DebW){1'b0}}, debounce_i};
  assign is_rot  = (cur_q == G_ROTATE_CW) || (cur_q == G_ROTATE_CCW);

  // priority: rotation on y, then flick on x, then flick on z
  always_comb begin
    cur_d = cur_q;
    stamp = 1'b0;
    if (open) begin
      stamp = 1'b1;
      if (flags_i.rot_pos) begin
        cur_d = (cur_q == G_ROTATE_CW) ? G_NONE : G_ROTATE_CCW;
      end else if (flags_i.rot_neg) begin
        cur_d = (cur_q == G_ROTATE_CCW) ? G_NONE : G_ROTATE_CW;
      end else if (flags_i.x_pos) begin
        cur_d = G_FLICK_DOWN;
      end else if (flags_i.x_neg) begin
        cur_d = G_FLICK_UP;
      end else if (flags_i.z_pos) begin
        cur_d = G_FLICK_LEFT;
      end else if (flags_i.z_neg) begin
        cur_d = G_FLICK_RIGHT;
      end else begin
        // quiet: rotations held, flicks cleared, no time stamp
        stamp = 1'b0;
        if (!is_rot) begin
          cur_d = G_NONE;
        end
      end
    end
    last_d = stamp ? now_ms_i : last_q;
  end

  // state advances only when the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= G_NONE;
      last_q <= '0;
    end else if (adv_i) begin
      cur_q  <= cur_d;
      last_q <= last_d;
    end
  end

  assign gesture_o = cur_d;

endmodule

// ===== rtl/gyro_gesture_event_detector.sv =====
// Gyro gesture event detector: one three-axis rate sample (signed Q12.4 deg/s) plus a
// millisecond timestamp in, one gesture code out per sample. Two register stages: a
// sample register feeding the comparators and the gesture state, and a result register
// on the output. The gesture state is updated in the same cycle the sample moves to the
// result register, so a new sample can be taken every clock unless a stalled result
// blocks the sample register. Result valid is set when the sample moves to the result
// register. Configuration writes take effect on the next clock
// and must be issued only while no sample is in flight.
// depends on ggd_pkg, ggd_axis_cmp, ggd_decide
module gyro_gesture_event_detector import ggd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [DebW-1:0]         cfg_wdata_i,
  // sample channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [RateW-1:0] rate_x_i,
  input  logic signed [RateW-1:0] rate_y_i,
  input  logic signed [RateW-1:0] rate_z_i,
  input  logic [TimeW-1:0]        now_ms_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              gesture_o
);

  logic [DebW-1:0] debounce_q;
  logic [ThrW-1:0] rotate_thr_q;
  logic [ThrW-1:0] flick_thr_q;

  logic                    s1_valid_q;
  logic signed [RateW-1:0] rx_q, ry_q, rz_q;
  logic [TimeW-1:0]        now_q;

  logic       out_valid_q;
  gesture_e   gesture_q;
  gesture_e   gesture_d;
  ggd_flags_t flags;
  logic       in_xfer;
  logic       adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceRst;
      rotate_thr_q <= RotateRst;
      flick_thr_q  <= FlickRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE: debounce_q   <= cfg_wdata_i;
        CFG_ROTATE:   rotate_thr_q <= cfg_wdata_i[ThrW-1:0];
        CFG_FLICK:    flick_thr_q  <= cfg_wdata_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // handshake: sample stage moves on when the result register is free or drains
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // sample register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rx_q  <= rate_x_i;
      ry_q  <= rate_y_i;
      rz_q  <= rate_z_i;
      now_q <= now_ms_i;
    end
  end

  ggd_axis_cmp u_cmp (
    .rate_x_i     (rx_q),
    .rate_y_i     (ry_q),
    .rate_z_i     (rz_q),
    .rotate_thr_i (rotate_thr_q),
    .flick_thr_i  (flick_thr_q),
    .flags_o      (flags)
  );

  ggd_decide u_decide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .flags_i    (flags),
    .now_ms_i   (now_q),
    .debounce_i (debounce_q),
    .gesture_o  (gesture_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gesture_q <= gesture_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gesture_o   = gesture_q;

endmodule

// ===== rtl/ggd_checker.sv =====
// port-level checker for the gyro gesture event detector, bound to the top level
// depends on ggd_pkg and gyro_gesture_event_detector_assert.svh
`include "gyro_gesture_event_detector_assert.svh"

module ggd_checker import ggd_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    cfg_we_i,
  input logic [CfgIdxW-1:0]      cfg_idx_i,
  input logic [DebW-1:0]         cfg_wdata_i,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic signed [RateW-1:0] rate_x_i,
  input logic signed [RateW-1:0] rate_y_i,
  input logic signed [RateW-1:0] rate_z_i,
  input logic [TimeW-1:0]        now_ms_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [2:0]              gesture_o
);

  // result held while stalled
  `GGD_ASSERT_HOLD(a_out_hold, out_valid_o, out_ready_i, gesture_o, "stalled result changed")

  // only defined gesture codes leave the block
  `GGD_ASSERT(a_code_range, out_valid_o |-> (gesture_o != 3'd7), "undefined gesture code")

  // a transferred sample with a ready output behind it moves through the sample register into a valid result
  `GGD_ASSERT(a_latency, (in_valid_i && in_ready_o) ##1 out_ready_i |=> out_valid_o, "result missing after transfer")

  // input side never blocked when nothing is pending
  `GGD_ASSERT(a_ready_idle, (!out_valid_o && !$past(in_valid_i && in_ready_o)) |-> in_ready_o, "input stalled while empty")

endmodule

bind gyro_gesture_event_detector ggd_checker u_ggd_checker (.*);
